### rtl/rwg_pkg.sv
// Shared types, constants and helper functions of the reference waveform generator.
// Used by rwg_divider, rwg_datapath, rwg_ctrl and the top level.
package rwg_pkg;

  localparam int DIV_W  = 50;  // dividend and quotient width of the serial divider
  localparam int DVS_W  = 18;  // divisor and remainder width
  localparam int CNT_W  = 6;   // divider step counter
  localparam int ACC_W  = 50;  // exact component sum
  localparam int TICK_W = 48;

  localparam logic [31:0] IMPULSE_LEVEL = 32'd65536;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam int SINE_DEN [7] = '{210, 156, 110, 72, 42, 20, 6};

  typedef enum logic [2:0] {
    REG_MODE_MASK    = 3'd0,
    REG_STEP_LEVEL   = 3'd1,
    REG_SQUARE_AMP   = 3'd2,
    REG_SQUARE_SHAPE = 3'd3,
    REG_SINE_AMP     = 3'd4,
    REG_SINE_PERIOD  = 3'd5,
    REG_TRI_AMP      = 3'd6,
    REG_TRI_PERIOD   = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DIV_SQ, OP_SQ_ADD, OP_DIV_SN, OP_SN_PHASE, OP_DIV_SI, OP_ROM,
    OP_SN_MUL, OP_SN_ADD, OP_DIV_TR, OP_TR_PHASE, OP_TR_MUL, OP_DIV_TQ, OP_TR_ADD, OP_FINISH
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_DIV, ST_SQ_WAIT, ST_SN_DIV, ST_SN_WAIT, ST_SI_DIV, ST_SI_WAIT,
    ST_SN_MUL, ST_SN_ADD, ST_TR_DIV, ST_TR_WAIT, ST_TR_MUL, ST_TQ_DIV, ST_TQ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // A period field of zero behaves as a period of one.
  function automatic logic [15:0] eff_period(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

  // sin(x) for x in [0, pi/2], Q2.30 in and out, truncating Horner evaluation.
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int i = 0; i < 7; i++) begin
      t = Q30_ONE - ((x2 * t) >> 30) / SINE_DEN[i];
    end
    t = (x * t) >> 30;
    return (t > Q30_ONE) ? Q30_ONE : t;
  endfunction

endpackage

### rtl/rwg_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rwg_pkg for widths.
module rwg_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [rwg_pkg::DIV_W-1:0] dividend,
  input  logic [rwg_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [rwg_pkg::DIV_W-1:0] quotient,
  output logic [rwg_pkg::DVS_W-1:0] remainder
);
  import rwg_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done && (dvs != '0) |-> rem < dvs)
    else $error("divider remainder not below divisor");

endmodule

### rtl/rwg_datapath.sv
// Datapath: configuration registers, tick counter, sine table, multipliers,
// accumulator and result registers. Depends on rwg_pkg and rwg_divider.
module rwg_datapath #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int SAMPLE_WIDTH       = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [31:0]         measured,
  input  rwg_pkg::op_t        op,
  output rwg_pkg::status_t    status,
  output logic [31:0]         setpoint,
  output logic [31:0]         error
);
  import rwg_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef logic signed [31:0] rom_t [SINE_TABLE_ENTRIES];

  // Quarter-wave fold of one full sine period into the table.
  function automatic rom_t build_rom();
    rom_t            r;
    longint unsigned a;
    longint unsigned s;
    logic            ng;
    for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
      a  = 4 * longint'(k);
      ng = 1'b0;
      if (a >= 2 * SINE_TABLE_ENTRIES) begin
        a  = a - 2 * SINE_TABLE_ENTRIES;
        ng = 1'b1;
      end
      if (a > SINE_TABLE_ENTRIES) a = 2 * SINE_TABLE_ENTRIES - a;
      s = sin_q30((a * PI_Q30 + SINE_TABLE_ENTRIES) / (2 * SINE_TABLE_ENTRIES));
      r[k] = ng ? -32'(s) : 32'(s);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // Configuration registers.
  logic [4:0]  mode_mask;
  logic [31:0] step_level, square_amplitude, square_shape, sine_amplitude;
  logic [31:0] triangle_amplitude;
  logic [15:0] sine_period, triangle_period;

  logic [TICK_W-1:0] tick_count, tick_next, tick_wrap_limit;
  logic [31:0]       limit_part, duty_product;
  logic [15:0]       p_sq, p_sn, p_tr;

  logic [15:0]             square_phase, sine_phase, triangle_phase;
  logic signed [ACC_W-1:0] acc, meas;
  logic signed [31:0]      rom_q;
  logic signed [63:0]      sn_prod;
  logic signed [19:0]      tri_m, m_next;
  logic signed [51:0]      tr_prod;
  logic [63:0]             sn_mag;
  logic [32:0]             sn_round;
  logic [51:0]             tr_mag;
  logic signed [ACC_W-1:0] sn_term, tr_term, err_full;
  logic [17:0]             f4, p3;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quot;
  logic [DVS_W-1:0] div_divisor, div_rem;
  logic [DIV_W-1:0] idx_wide;
  logic [IDX_W-1:0] rom_idx;

  assign p_sq = eff_period(square_shape[31:16]);
  assign p_sn = eff_period(sine_period);
  assign p_tr = eff_period(triangle_period);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_mask          <= '0;
      step_level         <= 32'd65536;
      square_amplitude   <= 32'd65536;
      square_shape       <= 32'd688128;
      sine_amplitude     <= 32'd65536;
      sine_period        <= 16'd10;
      triangle_amplitude <= 32'd65536;
      triangle_period    <= 16'd10;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE_MASK:    mode_mask          <= cfg_data[4:0];
        REG_STEP_LEVEL:   step_level         <= cfg_data;
        REG_SQUARE_AMP:   square_amplitude   <= cfg_data;
        REG_SQUARE_SHAPE: square_shape       <= cfg_data;
        REG_SINE_AMP:     sine_amplitude     <= cfg_data;
        REG_SINE_PERIOD:  sine_period        <= cfg_data[15:0];
        REG_TRI_AMP:      triangle_amplitude <= cfg_data;
        REG_TRI_PERIOD:   triangle_period    <= cfg_data[15:0];
      endcase
    end
  end

  // The wrap limit and the duty threshold are registered from the configuration
  // registers, long before any tick reaches the point where they are used.
  always_ff @(posedge clk) begin
    limit_part      <= p_sq * p_sn;
    tick_wrap_limit <= limit_part * p_tr;
    duty_product    <= square_shape[15:0] * p_sq;
  end

  assign tick_next = tick_count + TICK_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cfg_we && (reg_idx_t'(cfg_index) == REG_MODE_MASK)) begin
      tick_count <= '0;
    end else if (op == OP_FINISH) begin
      tick_count <= (tick_next >= tick_wrap_limit) ? '0 : tick_next;
    end
  end

  // Operands of the shared divider.
  always_comb begin
    div_start    = 1'b1;
    div_dividend = DIV_W'(tick_count);
    div_divisor  = DVS_W'(p_sq);
    unique case (op)
      OP_DIV_SQ: div_divisor = DVS_W'(p_sq);
      OP_DIV_SN: div_divisor = DVS_W'(p_sn);
      OP_DIV_TR: div_divisor = DVS_W'(p_tr);
      OP_DIV_SI: begin
        div_dividend = DIV_W'(sine_phase) * DIV_W'(2 * SINE_TABLE_ENTRIES) + DIV_W'(p_sn);
        div_divisor  = {1'b0, p_sn, 1'b0};
      end
      OP_DIV_TQ: begin
        div_dividend = {tr_mag[DIV_W-2:0], 1'b0} + DIV_W'(p_tr);
        div_divisor  = {1'b0, p_tr, 1'b0};
      end
      default: div_start = 1'b0;
    endcase
  end

  rwg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign status.div_done = div_done;

  // The rounded index can reach the table length, which folds back to zero.
  assign idx_wide = (div_quot >= DIV_W'(SINE_TABLE_ENTRIES)) ?
                    div_quot - DIV_W'(SINE_TABLE_ENTRIES) : div_quot;
  assign rom_idx  = idx_wide[IDX_W-1:0];

  // Triangle shape from the phase: rising, falling, rising again.
  assign f4 = {div_rem[15:0], 2'b00};
  assign p3 = {2'b00, p_tr} + {1'b0, p_tr, 1'b0};
  always_comb begin
    if (f4 < {2'b00, p_tr})  m_next = 20'(f4);
    else if (f4 < p3)        m_next = $signed({3'b000, p_tr, 1'b0}) - $signed(20'(f4));
    else                     m_next = $signed(20'(f4)) - $signed({2'b00, p_tr, 2'b00});
  end

  assign sn_mag   = sn_prod[63] ? 64'(-sn_prod) : 64'(sn_prod);
  assign sn_round = 33'((sn_mag + 64'd536870912) >> 30);
  assign sn_term  = sn_prod[63] ? -$signed(ACC_W'(sn_round)) : $signed(ACC_W'(sn_round));
  assign tr_mag   = tr_prod[51] ? 52'(-tr_prod) : 52'(tr_prod);
  assign tr_term  = tr_prod[51] ? -$signed(ACC_W'(div_quot[32:0]))
                                : $signed(ACC_W'(div_quot[32:0]));
  assign err_full = acc - meas;

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        meas <= ACC_W'($signed(measured));
        acc  <= (mode_mask[0] ? ACC_W'($signed(step_level)) : '0) +
                ((mode_mask[1] && tick_count == '0) ? ACC_W'(IMPULSE_LEVEL) : '0);
      end
      OP_SQ_ADD: begin
        square_phase <= div_rem[15:0];
        if (mode_mask[2] && ({div_rem[15:0], 16'd0} <= duty_product))
          acc <= acc + ACC_W'($signed(square_amplitude));
      end
      OP_SN_PHASE: sine_phase <= div_rem[15:0];
      OP_ROM:      rom_q <= SINE_ROM[rom_idx];
      OP_SN_MUL:   sn_prod <= $signed(sine_amplitude) * rom_q;
      OP_SN_ADD:   if (mode_mask[3]) acc <= acc + sn_term;
      OP_TR_PHASE: begin
        triangle_phase <= div_rem[15:0];
        tri_m          <= m_next;
      end
      OP_TR_MUL:   tr_prod <= $signed(triangle_amplitude) * tri_m;
      OP_TR_ADD:   if (mode_mask[4]) acc <= acc + tr_term;
      OP_FINISH: begin
        setpoint <= (acc > SAT_HI) ? SAT_HI[31:0] : (acc < SAT_LO) ? SAT_LO[31:0] : acc[31:0];
        error    <= (err_full > SAT_HI) ? SAT_HI[31:0] :
                    (err_full < SAT_LO) ? SAT_LO[31:0] : err_full[31:0];
      end
      default: ;
    endcase
  end

endmodule

### rtl/rwg_ctrl.sv
// Sequencer for one tick: square, sine and triangle passes through the shared
// divider, then the result hand-off. Depends on rwg_pkg.
module rwg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rwg_pkg::status_t status,
  output rwg_pkg::op_t     op
);
  import rwg_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op             = OP_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_SQ_DIV;
        end
      end
      ST_SQ_DIV:  begin op = OP_DIV_SQ; state_next = ST_SQ_WAIT; end
      ST_SQ_WAIT: if (status.div_done) begin op = OP_SQ_ADD; state_next = ST_SN_DIV; end
      ST_SN_DIV:  begin op = OP_DIV_SN; state_next = ST_SN_WAIT; end
      ST_SN_WAIT: if (status.div_done) begin op = OP_SN_PHASE; state_next = ST_SI_DIV; end
      ST_SI_DIV:  begin op = OP_DIV_SI; state_next = ST_SI_WAIT; end
      ST_SI_WAIT: if (status.div_done) begin op = OP_ROM; state_next = ST_SN_MUL; end
      ST_SN_MUL:  begin op = OP_SN_MUL; state_next = ST_SN_ADD; end
      ST_SN_ADD:  begin op = OP_SN_ADD; state_next = ST_TR_DIV; end
      ST_TR_DIV:  begin op = OP_DIV_TR; state_next = ST_TR_WAIT; end
      ST_TR_WAIT: if (status.div_done) begin op = OP_TR_PHASE; state_next = ST_TR_MUL; end
      ST_TR_MUL:  begin op = OP_TR_MUL; state_next = ST_TQ_DIV; end
      ST_TQ_DIV:  begin op = OP_DIV_TQ; state_next = ST_TQ_WAIT; end
      ST_TQ_WAIT: if (status.div_done) begin op = OP_TR_ADD; state_next = ST_FINISH; end
      ST_FINISH: begin
        // The result register is reloaded only once the previous item has left.
        if (!out_valid || out_ready) begin
          op             = OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    op == OP_FINISH |-> !out_valid || out_ready)
    else $error("result overwritten before it was taken");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == ST_SQ_WAIT || state == ST_SN_WAIT ||
                        state == ST_SI_WAIT || state == ST_TR_WAIT || state == ST_TQ_WAIT)
    else $error("divider finished outside a wait state");

endmodule

### rtl/reference_waveform_generator.sv
// Reference waveform generator: each input item is one control tick with a measured
// sample; each tick yields one item with the setpoint and the error. A tick is made
// of five passes through the 50-bit divider, which retires one quotient bit per
// cycle (square, sine and triangle phases, sine table index and triangle rounding),
// plus the accept, two sine, one triangle multiply and finish steps. A new item is
// taken while the previous result still waits at the output; a result held back by
// the receiver holds the next tick in its finish state until it is taken. Writing
// the mode mask restarts the tick counter; a period write reaches the wrap limit
// through the limit_part and tick_wrap_limit registers. Configuration must be
// written only while idle; the block itself does not enforce this.
module reference_waveform_generator #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int SAMPLE_WIDTH       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] measured
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [31:0] setpoint, [63:32] error
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rwg_pkg::*;

  op_t         op;
  status_t     status;
  logic [31:0] setpoint, error;

  rwg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .op        (op)
  );

  rwg_datapath #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES),
    .SAMPLE_WIDTH       (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .measured  (s_axis_tdata),
    .op        (op),
    .status    (status),
    .setpoint  (setpoint),
    .error     (error)
  );

  assign m_axis_tdata = {error, setpoint};

endmodule
